// ===== rtl/nmea_sentence_checker_core_assert.svh =====
// assertion macros for the checker's rtl, used by the result queue
`ifndef NMEA_SENTENCE_CHECKER_CORE_ASSERT_SVH
`define NMEA_SENTENCE_CHECKER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define NSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nmea checker: implication failed");

// next-cycle implication, sampled on clk, off while in reset
`define NSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nmea checker: next-cycle implication failed");

`endif

// ===== rtl/nmea_sc_pkg.sv =====
// shared types, character codes and helpers for the nmea sentence checker
package nmea_sc_pkg;

    // character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // sentence tags, three characters packed first-in highest
    localparam logic [23:0] TAG_GGA = 24'h474741;
    localparam logic [23:0] TAG_TRA = 24'h545241;
    localparam logic [23:0] TAG_RMC = 24'h524D43;

    // sentence kind codes
    localparam logic [1:0] KIND_GGA     = 2'd0;
    localparam logic [1:0] KIND_TRA     = 2'd1;
    localparam logic [1:0] KIND_RMC     = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // field positions and limits
    localparam logic [3:0] FIELD_FIX    = 4'd6;
    localparam logic [3:0] FIELD_SATS   = 4'd7;
    localparam logic [3:0] FIELD_STATUS = 4'd5;
    localparam logic [3:0] FIELD_MAX    = 4'd15;
    localparam logic [7:0] SAT_MAX      = 8'd99;
    localparam logic [1:0] DIGITS_BAD   = 2'd3;
    localparam logic [1:0] DIGITS_FULL  = 2'd2;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BODY,
        PH_HEX,
        PH_TRAIL
    } phase_t;

    typedef struct packed {
        logic [7:0]        computed_sum;
        logic [7:0]        received_sum;
        logic              heading_valid;
        logic [6:0]        satellite_count;
        logic signed [2:0] fix_status;
        logic [1:0]        sentence_kind;
        logic              checksum_ok;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } res_xfer_t;

    // hex digit decode: bit 4 set when the byte is a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r = {1'b1, b[3:0]};
        end
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
        begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    // gga fix quality to signed fix status
    function automatic logic signed [2:0] map_fix(input logic [7:0] q);
        logic signed [2:0] r;
        r = 3'sd0;
        if (q == 8'd0)
        begin
            r = -3'sd1;
        end
        else if (q == 8'd2 || q == 8'd5)
        begin
            r = 3'sd1;
        end
        else if (q == 8'd4)
        begin
            r = 3'sd2;
        end
        return r;
    endfunction

endpackage

// ===== rtl/nmea_sc_parser.sv =====
// per-byte sentence parser: state update and result build on line feed
module nmea_sc_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             data_byte,
    output nmea_sc_pkg::res_xfer_t res
);

    nmea_sc_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  hex_reg, hex_next;
    logic [1:0]  seen_reg, seen_next;
    logic [3:0]  field_num_reg, field_num_next;
    logic [7:0]  field_val_reg, field_val_next;
    logic [23:0] last3_reg, last3_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  fixq_reg, fixq_next;
    logic [6:0]  sat_reg, sat_next;
    logic [7:0]  tra_reg, tra_next;
    logic        skip_reg, skip_next;
    logic        closed_reg, closed_next;

    logic        do_start;
    logic        start_skip;
    logic        do_end;
    logic [4:0]  hd;
    logic        is_digit;
    logic [11:0] dec_sum;
    logic [1:0]  tag_kind;
    logic        ok;

    // decode helpers
    assign hd       = nmea_sc_pkg::hex_digit(data_byte);
    assign is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    assign dec_sum  = ({4'd0, field_val_reg} * 12'd10) + {8'd0, data_byte[3:0]};
    assign ok       = ((phase_reg == nmea_sc_pkg::PH_HEX) || (phase_reg == nmea_sc_pkg::PH_TRAIL))
                      && (seen_reg == nmea_sc_pkg::DIGITS_FULL) && (hex_reg == xor_reg);

    // tag match on the shifted window
    always_comb
    begin
        tag_kind = nmea_sc_pkg::KIND_UNKNOWN;
        if ({last3_reg[15:0], data_byte} == nmea_sc_pkg::TAG_GGA)
        begin
            tag_kind = nmea_sc_pkg::KIND_GGA;
        end
        if ({last3_reg[15:0], data_byte} == nmea_sc_pkg::TAG_TRA)
        begin
            tag_kind = nmea_sc_pkg::KIND_TRA;
        end
        if ({last3_reg[15:0], data_byte} == nmea_sc_pkg::TAG_RMC)
        begin
            tag_kind = nmea_sc_pkg::KIND_RMC;
        end
    end

    // next-state logic for one byte
    always_comb
    begin
        phase_next     = phase_reg;
        xor_next       = xor_reg;
        hex_next       = hex_reg;
        seen_next      = seen_reg;
        field_num_next = field_num_reg;
        field_val_next = field_val_reg;
        last3_next     = last3_reg;
        kind_next      = kind_reg;
        fixq_next      = fixq_reg;
        sat_next       = sat_reg;
        tra_next       = tra_reg;
        skip_next      = skip_reg;
        closed_next    = closed_reg;
        do_start       = 1'b0;
        start_skip     = 1'b0;
        do_end         = 1'b0;

        if (accept)
        begin
            if (data_byte == nmea_sc_pkg::CH_DOLLAR)
            begin
                do_start = 1'b1;
            end
            else if (data_byte == nmea_sc_pkg::CH_HASH)
            begin
                if (phase_reg == nmea_sc_pkg::PH_IDLE)
                begin
                    do_start   = 1'b1;
                    start_skip = 1'b1;
                end
                else
                begin
                    skip_next = 1'b1;
                end
            end
            else if (phase_reg == nmea_sc_pkg::PH_IDLE)
            begin
                phase_next = nmea_sc_pkg::PH_IDLE;
            end
            else if (data_byte == nmea_sc_pkg::CH_LF)
            begin
                phase_next = nmea_sc_pkg::PH_IDLE;
            end
            else if (phase_reg == nmea_sc_pkg::PH_BODY)
            begin
                if (data_byte == nmea_sc_pkg::CH_STAR)
                begin
                    do_end     = 1'b1;
                    phase_next = nmea_sc_pkg::PH_HEX;
                end
                else if (data_byte == nmea_sc_pkg::CH_COMMA)
                begin
                    xor_next = xor_reg ^ data_byte;
                    do_end   = 1'b1;
                end
                else
                begin
                    xor_next = xor_reg ^ data_byte;
                    if (field_num_reg == 4'd0)
                    begin
                        last3_next = {last3_reg[15:0], data_byte};
                        if (tag_kind != nmea_sc_pkg::KIND_UNKNOWN &&
                            (kind_reg == nmea_sc_pkg::KIND_UNKNOWN || tag_kind > kind_reg))
                        begin
                            kind_next = tag_kind;
                        end
                    end
                    else if (is_digit)
                    begin
                        if (!closed_reg)
                        begin
                            field_val_next = (dec_sum > 12'd255) ? 8'd255 : dec_sum[7:0];
                        end
                    end
                    else
                    begin
                        closed_next = 1'b1;
                    end
                end
            end
            else if (phase_reg == nmea_sc_pkg::PH_HEX)
            begin
                if (!hd[4])
                begin
                    seen_next  = nmea_sc_pkg::DIGITS_BAD;
                    phase_next = nmea_sc_pkg::PH_TRAIL;
                end
                else
                begin
                    hex_next  = {hex_reg[3:0], hd[3:0]};
                    seen_next = seen_reg + 2'd1;
                    if (seen_reg + 2'd1 >= nmea_sc_pkg::DIGITS_FULL)
                    begin
                        phase_next = nmea_sc_pkg::PH_TRAIL;
                    end
                end
            end
        end

        // close the current field
        if (do_end)
        begin
            if (kind_reg == nmea_sc_pkg::KIND_GGA && field_num_reg == nmea_sc_pkg::FIELD_FIX)
            begin
                fixq_next = field_val_reg;
            end
            if (kind_reg == nmea_sc_pkg::KIND_GGA && field_num_reg == nmea_sc_pkg::FIELD_SATS)
            begin
                sat_next = (field_val_reg > nmea_sc_pkg::SAT_MAX) ?
                           nmea_sc_pkg::SAT_MAX[6:0] : field_val_reg[6:0];
            end
            if (kind_reg == nmea_sc_pkg::KIND_TRA && field_num_reg == nmea_sc_pkg::FIELD_STATUS)
            begin
                tra_next = field_val_reg;
            end
            if (field_num_reg != nmea_sc_pkg::FIELD_MAX)
            begin
                field_num_next = field_num_reg + 4'd1;
            end
            field_val_next = 8'd0;
            closed_next    = 1'b0;
        end

        // fresh sentence
        if (do_start)
        begin
            phase_next     = nmea_sc_pkg::PH_BODY;
            xor_next       = 8'd0;
            hex_next       = 8'd0;
            seen_next      = 2'd0;
            field_num_next = 4'd0;
            field_val_next = 8'd0;
            last3_next     = 24'd0;
            kind_next      = nmea_sc_pkg::KIND_UNKNOWN;
            fixq_next      = 8'd0;
            sat_next       = 7'd0;
            tra_next       = 8'd0;
            skip_next      = start_skip;
            closed_next    = 1'b0;
        end
    end

    // result on a line feed that ends a sentence
    always_comb
    begin
        res       = '0;
        res.valid = accept && (data_byte == nmea_sc_pkg::CH_LF) &&
                    (phase_reg != nmea_sc_pkg::PH_IDLE) && !skip_reg;
        res.data.checksum_ok   = ok;
        res.data.sentence_kind = kind_reg;
        res.data.received_sum  = hex_reg;
        res.data.computed_sum  = xor_reg;
        if (ok && kind_reg == nmea_sc_pkg::KIND_GGA)
        begin
            res.data.fix_status      = nmea_sc_pkg::map_fix(fixq_reg);
            res.data.satellite_count = sat_reg;
        end
        res.data.heading_valid = ok && (kind_reg == nmea_sc_pkg::KIND_TRA) && (tra_reg == 8'd4);
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= nmea_sc_pkg::PH_IDLE;
            xor_reg       <= 8'd0;
            hex_reg       <= 8'd0;
            seen_reg      <= 2'd0;
            field_num_reg <= 4'd0;
            field_val_reg <= 8'd0;
            last3_reg     <= 24'd0;
            kind_reg      <= nmea_sc_pkg::KIND_UNKNOWN;
            fixq_reg      <= 8'd0;
            sat_reg       <= 7'd0;
            tra_reg       <= 8'd0;
            skip_reg      <= 1'b0;
            closed_reg    <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            xor_reg       <= xor_next;
            hex_reg       <= hex_next;
            seen_reg      <= seen_next;
            field_num_reg <= field_num_next;
            field_val_reg <= field_val_next;
            last3_reg     <= last3_next;
            kind_reg      <= kind_next;
            fixq_reg      <= fixq_next;
            sat_reg       <= sat_next;
            tra_reg       <= tra_next;
            skip_reg      <= skip_next;
            closed_reg    <= closed_next;
        end
    end

endmodule

// ===== rtl/nmea_sc_outq.sv =====
// two-entry result queue: output register plus skid slot
`include "nmea_sentence_checker_core_assert.svh"

module nmea_sc_outq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  nmea_sc_pkg::res_xfer_t res,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output nmea_sc_pkg::result_t   out_data
);

    logic [1:0]           count_reg, count_next;
    nmea_sc_pkg::result_t slot0_reg, slot0_next;
    nmea_sc_pkg::result_t slot1_reg, slot1_next;
    logic                 push;
    logic                 pop;

    assign push      = res.valid;
    assign pop       = out_valid && out_ready;
    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot0_reg;

    // queue update on push and pop
    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    slot0_next = res.data;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (pop && push)
                begin
                    slot0_next = res.data;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
                else if (push)
                begin
                    slot1_next = res.data;
                    count_next = 2'd2;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    slot0_next = slot1_reg;
                    count_next = 2'd1;
                end
            end
            default:
            begin
                count_next = 2'd0;
            end
        endcase
    end

    // queue registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            slot0_reg <= '0;
            slot1_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            slot0_reg <= slot0_next;
            slot1_reg <= slot1_next;
        end
    end

    // checks
    `NSC_ASSERT_NOW(a_no_push_when_full, push, count_reg != 2'd2)
    `NSC_ASSERT_NEXT(a_pop_only_drains, pop && !push, count_reg == $past(count_reg) - 2'd1)
    `NSC_ASSERT_NEXT(a_skid_captures, push && !pop && count_reg == 2'd1, slot1_reg == $past(res.data))

endmodule

// ===== rtl/nmea_sentence_checker_core.sv =====
// top level of the nmea sentence checker: byte stream in, sentence results out
//
//  channel | direction | tdata                        | notes
//  s_axis  | in        | [7:0] data_byte              | one ascii character per transfer
//  m_axis  | out       | [29:0] result, [31:30] zero  | one transfer per reported sentence
//
// one byte per cycle is taken while s_tready is high; the parser state updates in the same cycle
// a result is written into the output queue when its line feed is taken and waits behind any earlier untaken result
// a two-entry output queue keeps bytes flowing while one result is stalled
// s_tready drops only while both queue entries hold untaken results
// reset (rst_n low, asynchronous) returns the parser to idle and empties the queue
module nmea_sentence_checker_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] checksum_ok, [2:1] sentence_kind, [5:3] fix_status,
                                   // [12:6] satellite_count, [13] heading_valid,
                                   // [21:14] received_sum, [29:22] computed_sum, [31:30] zero
);

    nmea_sc_pkg::res_xfer_t res;
    nmea_sc_pkg::result_t   out_data;
    logic                   accept;

    // input transfer
    assign accept = s_tvalid && s_tready;

    // byte parser
    nmea_sc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_tdata),
        .res       (res)
    );

    // result queue
    nmea_sc_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    // pack result onto tdata
    assign m_tdata = {{(nmea_sc_pkg::DATA_W - $bits(nmea_sc_pkg::result_t)){1'b0}}, out_data};

endmodule
